// ----- src/sha1he_pkg.sv -----
// Shared types and constants of the SHA-1 hash engine.
// Holds the channel payloads, controller states, command and status groups.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sha1he_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_80,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      put_byte;
    byte_sel_t byte_sel;
    logic      add_len;
    logic [2:0] len_idx;
    logic      round_step;
    logic [1:0] round_phase;
    logic      chain_update;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } status_t;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockWords = 16;
  localparam logic [6:0]  LastRound  = 7'd79;
  localparam logic [5:0]  FillFull   = 6'd63;
  localparam logic [5:0]  FillLen    = 6'd56;
  localparam logic [2:0]  LastIndex  = 3'd4;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

endpackage

`default_nettype wire

// ----- src/sha1_hash_engine_core.sv -----
// SHA-1 hash engine over a byte stream, top level.
// The msg channel takes one item per transfer: an optional message byte and an
// end-of-message mark. The dig channel returns the five digest words of each
// message, h0 first, each with its word_index and with last_word on the fifth.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. Each byte is taken in the idle state without a stall. The byte
// that fills a 64-byte block is followed by the 80 compression rounds and the
// chain update, all with msg_stall high, so no new byte is taken until that
// block is through; a long message is limited by the single shared round unit.
// At the end of a message one or two final compressions run; the padding bytes
// are loaded one per cycle, except while a compression runs.
// The digest is then copied into an output buffer, the chain value returns to
// its initial value and new message bytes are taken while the digest drains.
// A stalled receiver holds the current word; a following end of message waits
// until the buffer has emptied. Reset is synchronous; it sets the chain value
// to H0-H4 and clears counters and output buffer state; no result is pending.
// Depends on sha1he_pkg, sha1he_ctrl and sha1he_datapath.
`default_nettype none

module sha1_hash_engine_core
  import sha1he_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output logic      msg_stall,
  input  wire msg_t msg,
  output logic      dig_valid,
  input  wire logic dig_stall,
  output dig_t      dig
);

  cmd_t    cmd;
  status_t status;

  sha1he_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg       (msg),
    .msg_stall (msg_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sha1he_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .msg       (msg),
    .status    (status),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && dig.last_word) |=> !dig_valid)
    else $error("digest buffer did not drain after the last word");

  assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig.last_word == (dig.word_index == LastIndex)))
    else $error("last_word does not match word_index");

  assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig.word_index <= LastIndex))
    else $error("word_index out of range");
`endif

endmodule

`default_nettype wire

// ----- src/sha1he_ctrl.sv -----
// Controller of the SHA-1 hash engine: state machine that sequences byte
// loading, padding, the 80 compression rounds and the digest handoff.
// Depends on sha1he_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module sha1he_ctrl
  import sha1he_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    msg_valid,
  input  wire msg_t    msg,
  output logic         msg_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [6:0] round, round_next;
  logic [2:0] len_idx, len_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ret     <= ST_IDLE;
      round   <= '0;
      len_idx <= '0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      round   <= round_next;
      len_idx <= len_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    round_next   = '0;
    len_idx_next = len_idx;
    case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (msg.has_byte && status.fill == FillFull) begin
            state_next = ST_ROUND;
            ret_next   = msg.end_of_message ? ST_PAD80 : ST_IDLE;
          end else if (msg.end_of_message) begin
            state_next = ST_PAD80;
          end
        end
      end
      ST_ROUND: begin
        if (round == LastRound) begin
          state_next = ST_UPDATE;
        end else begin
          round_next = round + 7'd1;
        end
      end
      ST_UPDATE: begin
        state_next = ret;
      end
      ST_PAD80: begin
        if (status.fill == FillFull) begin
          state_next = ST_ROUND;
          ret_next   = ST_PADZ;
        end else begin
          state_next = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (status.fill == FillLen) begin
          state_next   = ST_LEN;
          len_idx_next = '0;
        end else if (status.fill == FillFull) begin
          state_next = ST_ROUND;
          ret_next   = ST_PADZ;
        end
      end
      ST_LEN: begin
        len_idx_next = len_idx + 3'd1;
        if (len_idx == 3'd7) begin
          state_next = ST_ROUND;
          ret_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    msg_stall        = 1'b1;
    cmd              = '0;
    cmd.byte_sel     = BYTE_IN;
    cmd.len_idx      = len_idx;
    if (round < 7'd20) begin
      cmd.round_phase = 2'd0;
    end else if (round < 7'd40) begin
      cmd.round_phase = 2'd1;
    end else if (round < 7'd60) begin
      cmd.round_phase = 2'd2;
    end else begin
      cmd.round_phase = 2'd3;
    end
    case (state)
      ST_IDLE: begin
        msg_stall    = 1'b0;
        cmd.put_byte = msg_valid && msg.has_byte;
        cmd.add_len  = msg_valid && msg.has_byte;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.chain_update = 1'b1;
      end
      ST_PAD80: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = BYTE_80;
      end
      ST_PADZ: begin
        cmd.put_byte = status.fill != FillLen;
        cmd.byte_sel = BYTE_ZERO;
      end
      ST_LEN: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = BYTE_LEN;
      end
      ST_FINISH: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        msg_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sha1he_datapath.sv -----
// Datapath of the SHA-1 hash engine: byte packer, 16-word schedule window,
// round logic, chain value, bit length and the digest output buffer.
// Depends on sha1he_pkg; takes cmd_t from the controller, returns status_t.
`default_nettype none

module sha1he_datapath
  import sha1he_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire msg_t msg,
  output status_t   status,
  output logic      dig_valid,
  input  wire logic dig_stall,
  output dig_t      dig
);

  logic [31:0] window [BlockWords];
  logic [31:0] chain  [NumWords];
  logic [31:0] rv     [NumWords];
  logic [31:0] out_buf [NumWords];
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [2:0]  out_idx;
  logic        out_busy;

  logic [7:0]  byte_val;
  logic [31:0] new_word;
  logic [31:0] sched_word;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] n_val;
  logic [31:0] a, b, c, d, e;
  logic        word_done;
  logic        dig_xfer;

  assign a = rv[0];
  assign b = rv[1];
  assign c = rv[2];
  assign d = rv[3];
  assign e = rv[4];

  always_comb begin
    case (cmd.byte_sel)
      BYTE_IN:   byte_val = msg.message_byte;
      BYTE_80:   byte_val = PadByte;
      BYTE_ZERO: byte_val = 8'h00;
      BYTE_LEN:  byte_val = bit_len[{~cmd.len_idx, 3'b000} +: 8];
      default:   byte_val = 8'h00;
    endcase
  end

  assign new_word  = {acc, byte_val};
  assign word_done = cmd.put_byte && (fill[1:0] == 2'b11);

  always_comb begin
    sched_word = window[13] ^ window[8] ^ window[2] ^ window[0];
    sched_word = {sched_word[30:0], sched_word[31]};
  end

  always_comb begin
    case (cmd.round_phase)
      2'd0: begin
        f_val = (b & c) | (~b & d);
        k_val = K0;
      end
      2'd1: begin
        f_val = b ^ c ^ d;
        k_val = K1;
      end
      2'd2: begin
        f_val = (b & c) | (b & d) | (c & d);
        k_val = K2;
      end
      default: begin
        f_val = b ^ c ^ d;
        k_val = K3;
      end
    endcase
  end

  assign n_val = {a[26:0], a[31:27]} + f_val + e + k_val + window[0];

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      acc <= new_word[23:0];
    end
    if (word_done || cmd.round_step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[BlockWords - 1] <= cmd.round_step ? sched_word : new_word;
    end
    if (cmd.put_byte && fill == FillFull) begin
      for (int i = 0; i < NumWords; i++) begin
        rv[i] <= chain[i];
      end
    end else if (cmd.round_step) begin
      rv[0] <= n_val;
      rv[1] <= a;
      rv[2] <= {b[1:0], b[31:2]};
      rv[3] <= c;
      rv[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= H0;
      chain[1] <= H1;
      chain[2] <= H2;
      chain[3] <= H3;
      chain[4] <= H4;
      fill     <= '0;
      bit_len  <= '0;
    end else begin
      if (cmd.put_byte) begin
        fill <= fill + 6'd1;
      end
      if (cmd.add_len) begin
        bit_len <= bit_len + 64'd8;
      end
      if (cmd.chain_update) begin
        for (int i = 0; i < NumWords; i++) begin
          chain[i] <= chain[i] + rv[i];
        end
      end else if (cmd.finish) begin
        chain[0] <= H0;
        chain[1] <= H1;
        chain[2] <= H2;
        chain[3] <= H3;
        chain[4] <= H4;
        bit_len  <= '0;
      end
    end
  end

  assign dig_xfer = out_busy && !dig_stall;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < NumWords; i++) begin
        out_buf[i] <= chain[i];
      end
    end else if (dig_xfer) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        out_buf[i] <= out_buf[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (cmd.finish) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (dig_xfer) begin
      if (out_idx == LastIndex) begin
        out_busy <= 1'b0;
      end
      out_idx <= out_idx + 3'd1;
    end
  end

  assign dig_valid        = out_busy;
  assign dig.digest_word  = out_buf[0];
  assign dig.word_index   = out_idx;
  assign dig.last_word    = out_idx == LastIndex;

  assign status.fill     = fill;
  assign status.out_busy = out_busy;

endmodule

`default_nettype wire
